// ----- rtl/sfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sensor field decoder
// Item structs, register map, decoded configuration and result codes.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned MAX_REPLY_BYTES_DEF = 64;

    // register map of the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_OFFSET = 3'd0,
        REG_FORMAT_WORD   = 3'd1,
        REG_VALUE_MASK    = 3'd2,
        REG_INVALID_CODE  = 3'd3,
        REG_GAIN          = 3'd4,
        REG_BIAS          = 3'd5,
        REG_LOWER_LIMIT   = 3'd6,
        REG_UPPER_LIMIT   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_INVALID_CODE = 2'd1,
        ERR_WINDOW       = 2'd2
    } err_code_t;

    // Q32.16 limits of the result
    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    // bound on the product before the bias is added (2^50)
    localparam logic signed [64:0] PROD_HI = 65'sh0_0004_0000_0000_0000;
    localparam logic signed [64:0] PROD_LO = -PROD_HI;

    // reset values of the registers
    localparam logic [31:0]        RST_VALUE_MASK = 32'h0000_00FF;
    localparam logic signed [31:0] RST_GAIN       = 32'sh0001_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic signed [47:0] sample_value;
        logic               sample_valid;
        logic [1:0]         error_code;
    } result_item_t;

    // configuration with the format word already split into its fields
    typedef struct packed {
        logic [5:0]         window_offset;
        logic [1:0]         width_m1;
        logic               lsb_first;
        logic               signed_en;
        logic               check_en;
        logic [4:0]         shift;
        logic [31:0]        value_mask;
        logic [31:0]        invalid_code;
        logic signed [31:0] gain;
        logic signed [47:0] bias;
        logic signed [47:0] lower_limit;
        logic signed [47:0] upper_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/sensor_field_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_field_decoder_unit: sensor reply field decoder
// Captures a 1 to 4 byte field from a reply byte stream and turns it into a
// scaled, clamped Q32.16 sample.
// ----------------------------------------------------------------------------
// Usage:
//   byte_*   : one reply byte per item; last_byte closes the reply and
//              starts the decode. Bytes that are not last give no result.
//   result_* : one item per reply: sample_value (Q32.16), sample_valid,
//              error_code (window beyond reply, or invalid raw code).
//   cfg_*    : register writes, always ready; write only while idle.
// Throughput: one byte per cycle unless a stall fills the five-stage pipeline
//   (capture, extract, multiply, bias add, saturate/clamp into result reg).
// Result path: the last byte is registered in stage 1 and moves on to the result reg.
// Reset: clears the byte counter, window and all pipeline valids; the
//   registers take their reset values (mask 0xFF, gain 1.0, full limits).
// Stall: when result_ready is low the result register holds, stages behind
//   it fill, and byte_ready drops only once every stage holds an item.
//   Bytes past MAX_REPLY_BYTES are dropped; the length saturates there.
// ----------------------------------------------------------------------------
module sensor_field_decoder_unit
    import sfd_pkg::*;
#(
    parameter int unsigned MAX_REPLY_BYTES = MAX_REPLY_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    output logic                        byte_ready,
    input  wire byte_item_t             byte_item,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_item_t                result_item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // counter holds 0..MAX_REPLY_BYTES; compare width also covers offset+width
    localparam int unsigned POS_W = $clog2(MAX_REPLY_BYTES + 1);
    localparam int unsigned CMP_W = (POS_W > 7) ? POS_W : 7;

    cfg_t cfg;

    assign cfg_ready = 1'b1;

    sfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // pipeline handshake: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic result_valid_reg;
    logic out_load;
    logic s4_load;
    logic s3_load;
    logic s2_load;
    logic s1_load;
    logic byte_accept;

    assign out_load    = !result_valid_reg || result_ready;
    assign s4_load     = !s4_valid_reg || out_load;
    assign s3_load     = !s3_valid_reg || s4_load;
    assign s2_load     = !s2_valid_reg || s3_load;
    assign s1_load     = !s1_valid_reg || s2_load;
    assign byte_ready  = s1_load;
    assign byte_accept = byte_valid && byte_ready;

    // ------------------------------------------------------------------
    // byte capture
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      window_reg;
    logic [31:0]      window_next;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] offs_ext;
    logic [CMP_W-1:0] win_end;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] slot_full;
    logic [1:0]       slot;
    logic             pos_room;

    assign pos_ext   = CMP_W'(pos_reg);
    assign offs_ext  = CMP_W'(cfg.window_offset);
    assign win_end   = offs_ext + CMP_W'(cfg.width_m1) + CMP_W'(1);
    assign pos_room  = (pos_reg < POS_W'(MAX_REPLY_BYTES));
    assign slot_full = pos_ext - offs_ext;
    assign slot      = slot_full[1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        window_next = window_reg;
        if (pos_room)
        begin
            // merge the byte into its lane when it falls inside the window
            if ((pos_ext >= offs_ext) && (pos_ext < win_end))
            begin
                case (slot)
                    2'd0:    window_next[7:0]   = window_reg[7:0]   | byte_item.data_byte;
                    2'd1:    window_next[15:8]  = window_reg[15:8]  | byte_item.data_byte;
                    2'd2:    window_next[23:16] = window_reg[23:16] | byte_item.data_byte;
                    2'd3:    window_next[31:24] = window_reg[31:24] | byte_item.data_byte;
                    default: window_next = window_reg;
                endcase
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    assign len_ext = CMP_W'(pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            window_reg <= '0;
        end
        else if (byte_accept)
        begin
            // restart the reply after its last byte
            if (byte_item.last_byte)
            begin
                pos_reg    <= '0;
                window_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                window_reg <= window_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: finished window and length check
    // ------------------------------------------------------------------
    logic [31:0] s1_window_reg;
    logic        s1_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= byte_accept && byte_item.last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_window_reg <= window_next;
            s1_err_reg    <= (win_end > len_ext);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: numeric value and invalid code check
    // ------------------------------------------------------------------
    logic signed [32:0] numeric;
    logic               invalid_hit;
    logic signed [32:0] s2_numeric_reg;
    logic               s2_hit_reg;
    logic               s2_err_reg;

    sfd_field_extract u_extract (
        .window      (s1_window_reg),
        .cfg         (cfg),
        .numeric     (numeric),
        .invalid_hit (invalid_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_numeric_reg <= numeric;
            s2_hit_reg     <= invalid_hit;
            s2_err_reg     <= s1_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: exact product with the Q16.16 gain
    // ------------------------------------------------------------------
    logic signed [64:0] prod_next;
    logic signed [64:0] s3_prod_reg;
    logic               s3_hit_reg;
    logic               s3_err_reg;

    assign prod_next = 65'(s2_numeric_reg) * 65'(cfg.gain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_prod_reg <= prod_next;
            s3_hit_reg  <= s2_hit_reg;
            s3_err_reg  <= s2_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: bound the product, add the bias
    // ------------------------------------------------------------------
    logic signed [51:0] prod_bounded;
    logic signed [51:0] sum_next;
    logic signed [51:0] s4_sum_reg;
    logic               s4_hit_reg;
    logic               s4_err_reg;

    always_comb
    begin
        if (s3_prod_reg > PROD_HI)
        begin
            prod_bounded = PROD_HI[51:0];
        end
        else if (s3_prod_reg < PROD_LO)
        begin
            prod_bounded = PROD_LO[51:0];
        end
        else
        begin
            prod_bounded = s3_prod_reg[51:0];
        end
    end

    assign sum_next = prod_bounded + 52'(cfg.bias);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_load)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            s4_sum_reg <= sum_next;
            s4_hit_reg <= s3_hit_reg;
            s4_err_reg <= s3_err_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: saturate to 48 bits, clamp, build the result item
    // ------------------------------------------------------------------
    logic signed [47:0] sat_value;
    logic signed [47:0] clamp_value;
    result_item_t       result_next;
    result_item_t       result_item_reg;

    always_comb
    begin
        if (s4_sum_reg > 52'(MAX48))
        begin
            sat_value = MAX48;
        end
        else if (s4_sum_reg < 52'(MIN48))
        begin
            sat_value = MIN48;
        end
        else
        begin
            sat_value = s4_sum_reg[47:0];
        end

        // lower limit is tested first: with crossed limits, values below it take it, others the upper
        if (sat_value < cfg.lower_limit)
        begin
            clamp_value = cfg.lower_limit;
        end
        else if (sat_value > cfg.upper_limit)
        begin
            clamp_value = cfg.upper_limit;
        end
        else
        begin
            clamp_value = sat_value;
        end

        if (s4_err_reg)
        begin
            result_next.sample_value = '0;
            result_next.sample_valid = 1'b0;
            result_next.error_code   = ERR_WINDOW;
        end
        else if (s4_hit_reg)
        begin
            result_next.sample_value = clamp_value;
            result_next.sample_valid = 1'b0;
            result_next.error_code   = ERR_INVALID_CODE;
        end
        else
        begin
            result_next.sample_value = clamp_value;
            result_next.sample_valid = 1'b1;
            result_next.error_code   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_item_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule
`default_nettype wire

// ----- rtl/sfd_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_cfg_regs: configuration register file
// Holds the eight decoder registers and presents them as one decoded struct.
// ----------------------------------------------------------------------------
module sfd_cfg_regs
    import sfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_OFFSET: cfg_next.window_offset = cfg_data[5:0];
                REG_FORMAT_WORD:
                begin
                    cfg_next.width_m1  = cfg_data[1:0];
                    cfg_next.lsb_first = cfg_data[2];
                    cfg_next.signed_en = cfg_data[3];
                    cfg_next.check_en  = cfg_data[4];
                    cfg_next.shift     = cfg_data[9:5];
                end
                REG_VALUE_MASK:   cfg_next.value_mask   = cfg_data[31:0];
                REG_INVALID_CODE: cfg_next.invalid_code = cfg_data[31:0];
                REG_GAIN:         cfg_next.gain         = cfg_data[31:0];
                REG_BIAS:         cfg_next.bias         = cfg_data[47:0];
                REG_LOWER_LIMIT:  cfg_next.lower_limit  = cfg_data[47:0];
                REG_UPPER_LIMIT:  cfg_next.upper_limit  = cfg_data[47:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_offset <= '0;
            cfg_reg.width_m1      <= '0;
            cfg_reg.lsb_first     <= 1'b0;
            cfg_reg.signed_en     <= 1'b0;
            cfg_reg.check_en      <= 1'b0;
            cfg_reg.shift         <= '0;
            cfg_reg.value_mask    <= RST_VALUE_MASK;
            cfg_reg.invalid_code  <= '0;
            cfg_reg.gain          <= RST_GAIN;
            cfg_reg.bias          <= '0;
            cfg_reg.lower_limit   <= MIN48;
            cfg_reg.upper_limit   <= MAX48;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- rtl/sfd_field_extract.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_field_extract: window to numeric value
// Orders the window bytes, shifts, masks, sign-extends and checks the code.
// ----------------------------------------------------------------------------
module sfd_field_extract
    import sfd_pkg::*;
(
    input  wire logic [31:0]        window,
    input  wire cfg_t               cfg,
    output logic signed [32:0]      numeric,
    output logic                    invalid_hit
);

    logic [31:0] raw;
    logic [31:0] masked;
    logic [2:0]  width_bytes;
    logic [5:0]  width_bits;
    logic [5:0]  eff_bits;
    logic        ext_allowed;
    logic [4:0]  top_bit;
    logic        do_ext;
    logic [32:0] ext_fill;

    // window slots above the width stay zero, so little endian is the window itself
    always_comb
    begin
        if (cfg.lsb_first)
        begin
            raw = window;
        end
        else
        begin
            case (cfg.width_m1)
                2'd0:    raw = {24'd0, window[7:0]};
                2'd1:    raw = {16'd0, window[7:0], window[15:8]};
                2'd2:    raw = {8'd0, window[7:0], window[15:8], window[23:16]};
                2'd3:    raw = {window[7:0], window[15:8], window[23:16], window[31:24]};
                default: raw = window;
            endcase
        end
    end

    assign masked      = (raw >> cfg.shift) & cfg.value_mask;
    assign width_bytes = {1'b0, cfg.width_m1} + 3'd1;
    assign width_bits  = {width_bytes, 3'b000};
    assign ext_allowed = cfg.signed_en && ({1'b0, cfg.shift} < width_bits);
    assign eff_bits    = width_bits - {1'b0, cfg.shift};

    // highest mask bit inside the bits left after the shift; bit 0 if none
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (cfg.value_mask[i] && (6'(i) < eff_bits))
            begin
                top_bit = 5'(i);
            end
        end
    end

    assign do_ext   = ext_allowed && masked[top_bit];
    assign ext_fill = {33{1'b1}} << ({1'b0, top_bit} + 6'd1);
    assign numeric  = {1'b0, masked} | (do_ext ? ext_fill : 33'd0);

    // a negative value never equals the zero-extended code
    assign invalid_hit = cfg.check_en && (numeric == {1'b0, cfg.invalid_code});

endmodule
`default_nettype wire
